### src/int8_matrix_vector_bias_scale_assert.svh
// Assertion macros for the int8 matrix-vector block.
// Used by the queue and back-end modules; no other dependencies.
`ifndef INT8_MATRIX_VECTOR_BIAS_SCALE_ASSERT_SVH
`define INT8_MATRIX_VECTOR_BIAS_SCALE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset
`define IMVBS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("imvbs assertion failed");
// Expression must never be true outside reset
`define IMVBS_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("imvbs forbidden condition");
`else
`define IMVBS_ASSERT(lbl, clk, rst, prop)
`define IMVBS_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

### src/imvbs_pkg.sv
// Shared constants and types for the int8 matrix-vector block.
// No dependencies.
package imvbs_pkg;

   // Field widths
   localparam int MAX_INPUTS = 1024;
   localparam int POS_W      = $clog2(MAX_INPUTS);
   localparam int ROW_W      = 12;
   localparam int DATA_W     = 8;
   localparam int SCALE_W    = 32;
   localparam int SUM_W      = 57;

   // Arithmetic widths
   localparam int MUL_W      = 2 * DATA_W;
   localparam int ACC_W      = 26;
   localparam int TOTAL_W    = ACC_W + 1;
   localparam int PROD_W     = TOTAL_W + SCALE_W;

   // Quantized value of an input of one, applied to the bias weight
   localparam logic signed [DATA_W-1:0] ACT_ONE  = 8'sd127;
   localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};

   // Operation codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_WEIGHT = 1'b1;

   // Queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   // One weight item after its activation has been fetched
   typedef struct packed {
      logic                      row_end;
      logic signed [DATA_W-1:0]  weight;
      logic signed [DATA_W-1:0]  activation;
      logic signed [SCALE_W-1:0] row_scale;
   } entry_type;

   // Queue write side
   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   // Queue read side status
   typedef struct packed {
      logic      empty;
      entry_type entry;
   } head_type;

endpackage

### src/imvbs_ifs.sv
// Valid/ready channel interfaces for request and response items.
// Depends on imvbs_pkg.
interface imvbs_req_if import imvbs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [POS_W-1:0]          position;
   logic signed [DATA_W-1:0]  activation;
   logic signed [DATA_W-1:0]  weight;
   logic                      row_end;
   logic signed [SCALE_W-1:0] row_scale;

   modport source (output valid, operation, position, activation, weight, row_end,
                   row_scale, input ready);
   modport sink (input valid, operation, position, activation, weight, row_end,
                 row_scale, output ready);
endinterface

interface imvbs_rsp_if import imvbs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ROW_W-1:0]        row_number;
   logic signed [SUM_W-1:0] scaled_sum;

   modport source (output valid, row_number, scaled_sum, input ready);
   modport sink (input valid, row_number, scaled_sum, output ready);
endinterface

### src/imvbs_front.sv
// Front end: accepts items, owns the activation store, fetches activations.
// Depends on imvbs_pkg and imvbs_req_if.
module imvbs_front import imvbs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   imvbs_req_if.sink     req_chan,
   output push_type      push_out,
   input  logic          fifo_full
);

   logic signed [DATA_W-1:0] act_mem [MAX_INPUTS];

   logic                      stg_valid_ff, stg_valid_in;
   logic                      stg_end_ff;
   logic signed [DATA_W-1:0]  stg_weight_ff;
   logic signed [DATA_W-1:0]  stg_act_ff;
   logic signed [SCALE_W-1:0] stg_scale_ff;

   logic accept, is_weight, push;

   // Handshake: the fetch stage frees when its item moves into the queue
   assign push               = stg_valid_ff && !fifo_full;
   assign req_chan.ready     = !stg_valid_ff || !fifo_full;
   assign accept             = req_chan.valid && req_chan.ready;
   assign is_weight          = (req_chan.operation == OP_WEIGHT);

   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (accept && is_weight) begin
         stg_valid_in = 1'b1;
      end else if (push) begin
         stg_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   // Activation store: write on load, registered read on weight
   always_ff @(posedge clock) begin
      if (accept && (req_chan.operation == OP_LOAD)) begin
         act_mem[req_chan.position] <= req_chan.activation;
      end
      if (accept && is_weight) begin
         stg_act_ff <= act_mem[req_chan.position];
      end
   end

   // Fetch stage payload
   always_ff @(posedge clock) begin
      if (accept && is_weight) begin
         stg_end_ff    <= req_chan.row_end;
         stg_weight_ff <= req_chan.weight;
         stg_scale_ff  <= req_chan.row_scale;
      end
   end

   assign push_out.push             = push;
   assign push_out.entry.row_end    = stg_end_ff;
   assign push_out.entry.weight     = stg_weight_ff;
   assign push_out.entry.activation = stg_act_ff;
   assign push_out.entry.row_scale  = stg_scale_ff;

endmodule

### src/imvbs_fifo.sv
// Short queue of fetched weight items between front and back end.
// Depends on imvbs_pkg and the assertion macro header.
`include "int8_matrix_vector_bias_scale_assert.svh"
module imvbs_fifo import imvbs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push_in,
   output logic     full,
   output head_type head,
   input  logic     pop
);

   entry_type             slots [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign head.empty = (count_ff == '0);
   assign head.entry = slots[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_in.push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({push_in.push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         slots[wr_ptr_ff] <= push_in.entry;
      end
   end

   `IMVBS_ASSERT_NEVER(a_no_push_full, clock, reset, push_in.push && full)
   `IMVBS_ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && head.empty)

endmodule

### src/imvbs_back.sv
// Back end: row accumulator, bias, scaling pipeline and result register.
// Depends on imvbs_pkg, imvbs_rsp_if and the assertion macro header.
`include "int8_matrix_vector_bias_scale_assert.svh"
module imvbs_back import imvbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  head_type   head,
   output logic       pop,
   imvbs_rsp_if.source rsp_chan
);

   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [ROW_W-1:0]          row_cnt_ff, row_cnt_in;
   logic signed [MUL_W-1:0]   mul, bias_mul;

   // Stage A: biased total
   logic                      a_valid_ff, a_valid_in;
   logic signed [TOTAL_W-1:0] total_ff;
   logic signed [SCALE_W-1:0] scale_a_ff;
   logic [ROW_W-1:0]          row_a_ff;

   // Stage B: full product
   logic                      b_valid_ff, b_valid_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [ROW_W-1:0]          row_b_ff;

   // Result register
   logic                      out_valid_ff, out_valid_in;
   logic [ROW_W-1:0]          out_row_ff;
   logic signed [SUM_W-1:0]   out_sum_ff, sum_sat;

   logic out_free, b_adv, b_free, a_adv, a_free, pop_end, pop_mac;

   // Pipeline flow control
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign b_adv    = b_valid_ff && out_free;
   assign b_free   = !b_valid_ff || b_adv;
   assign a_adv    = a_valid_ff && b_free;
   assign a_free   = !a_valid_ff || a_adv;
   assign pop      = !head.empty && (!head.entry.row_end || a_free);
   assign pop_end  = pop && head.entry.row_end;
   assign pop_mac  = pop && !head.entry.row_end;

   // Products of the weight with its activation and with the bias input
   assign mul      = MUL_W'(head.entry.weight) * MUL_W'(head.entry.activation);
   assign bias_mul = MUL_W'(head.entry.weight) * MUL_W'(ACT_ONE);

   always_comb begin
      acc_in     = acc_ff;
      row_cnt_in = row_cnt_ff;
      if (pop_mac) begin
         acc_in = acc_ff + ACC_W'(mul);
      end else if (pop_end) begin
         acc_in     = '0;
         row_cnt_in = row_cnt_ff + 1'b1;
      end
   end

   // Valid bits of the scaling pipeline
   always_comb begin
      a_valid_in   = pop_end ? 1'b1 : (a_adv ? 1'b0 : a_valid_ff);
      b_valid_in   = a_adv ? 1'b1 : (b_adv ? 1'b0 : b_valid_ff);
      out_valid_in = b_adv ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   end

   assign prod_in = total_ff * scale_a_ff;

   // Saturate the product to the result width
   always_comb begin
      if ((prod_ff[PROD_W-1:SUM_W-1] == '0) || (prod_ff[PROD_W-1:SUM_W-1] == '1)) begin
         sum_sat = prod_ff[SUM_W-1:0];
      end else if (prod_ff[PROD_W-1]) begin
         sum_sat = SUM_MIN;
      end else begin
         sum_sat = SUM_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         row_cnt_ff   <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         row_cnt_ff   <= row_cnt_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (pop_end) begin
         total_ff   <= TOTAL_W'(acc_ff) + TOTAL_W'(bias_mul);
         scale_a_ff <= head.entry.row_scale;
         row_a_ff   <= row_cnt_ff;
      end
      if (a_adv) begin
         prod_ff  <= prod_in;
         row_b_ff <= row_a_ff;
      end
      if (b_adv) begin
         out_sum_ff <= sum_sat;
         out_row_ff <= row_b_ff;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.row_number = out_row_ff;
   assign rsp_chan.scaled_sum = out_sum_ff;

   `IMVBS_ASSERT(a_acc_clear, clock, reset, pop_end |=> (acc_ff == '0))
   `IMVBS_ASSERT(a_stage_hold, clock, reset, (a_valid_ff && !b_free) |=> a_valid_ff)

endmodule

### src/int8_matrix_vector_bias_scale.sv
// Int8 matrix-vector multiply with row bias and row scale. The block takes one
// item per clock when nothing downstream stalls: a load writes one activation
// into a 1024-entry single-port store, a weight item reads its activation from
// that store in its accept cycle and is then accumulated by the back end one
// item per clock, and a row-end item starts a two-stage scaling pipeline
// (bias add, then a 27 x 32 multiply) that also runs at one row per clock.
// A row result moves from the fetch stage through the queue, stage A and stage B
// into the response register. A four-entry queue between the fetch stage and the
// accumulator lets the request and response sides stall independently.
// No clearing pass after reset; reading an activation never loaded is undefined.
// Depends on imvbs_pkg, imvbs_ifs, imvbs_front, imvbs_fifo and imvbs_back.
module int8_matrix_vector_bias_scale import imvbs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   imvbs_req_if.sink    req_chan,
   imvbs_rsp_if.source  rsp_chan
);

   push_type push;
   head_type head;
   logic     fifo_full;
   logic     pop;

   imvbs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .push_out  (push),
      .fifo_full (fifo_full)
   );

   imvbs_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .full    (fifo_full),
      .head    (head),
      .pop     (pop)
   );

   imvbs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
